// ===== sv/mfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mfq_pkg : multilevel feedback queue scheduler package
// Field widths, operation and status codes, and shared record types.
// ----------------------------------------------------------------------------
package mfq_pkg;

   localparam int unsigned TASK_W   = 6;
   localparam int unsigned LEVEL_W  = 3;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned THR_W    = 10;
   localparam int unsigned OP_W     = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned PCOUNT_W = 7;

   localparam int unsigned DEF_MAX_TASKS  = 64;
   localparam int unsigned DEF_NUM_LEVELS = 5;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(50);

   localparam logic [OP_W-1:0] OP_ENQUEUE  = OP_W'(0);
   localparam logic [OP_W-1:0] OP_DISPATCH = OP_W'(1);
   localparam logic [OP_W-1:0] OP_RETURN   = OP_W'(2);
   localparam logic [OP_W-1:0] OP_REMOVE   = OP_W'(3);
   localparam logic [OP_W-1:0] OP_AGE      = OP_W'(4);

   localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_FULL      = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_EMPTY     = STATUS_W'(3);

   typedef struct packed {
      logic [TASK_W-1:0]  id;
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]  stamp;
   } entry_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]  stamp;
   } tinfo_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// ===== sv/mfq_cell.sv =====
// ----------------------------------------------------------------------------
// mfq_cell : queue chain cell
// Holds one queued task; loads a new entry or takes its upper neighbour's.
// ----------------------------------------------------------------------------
module mfq_cell
   import mfq_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    nbr_e,
   input  entry_type    load_e,
   output entry_type    cell_e
);

   entry_type cell_ff;
   entry_type cell_in;

   always_comb begin
      cell_in = cell_ff;
      if (ctl.load) begin
         cell_in = load_e;
      end else if (ctl.shift) begin
         cell_in = nbr_e;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_e = cell_ff;

endmodule

// ===== sv/mfq_tinfo.sv =====
// ----------------------------------------------------------------------------
// mfq_tinfo : per-task level and timestamp store
// One write and one registered read per cycle; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module mfq_tinfo
   import mfq_pkg::*;
#(
   parameter int unsigned DEPTH = DEF_MAX_TASKS,
   parameter int unsigned IDX_W = 6
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   output tinfo_type        rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  tinfo_type        wr_data
);

   tinfo_type        tinfo_mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   tinfo_type        rd_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tinfo_mem[wr_addr] <= wr_data;
      end
      rd_ff <= tinfo_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_ff : '0;

endmodule

// ===== sv/multilevel_feedback_queue_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_top : five-level feedback queue scheduler
// Queued tasks sit in push order in a chain of cells; ops sweep the chain.
// ----------------------------------------------------------------------------
// Steps: enqueue, return and unknown ops execute and then respond; dispatch and
//   remove also sweep the queued tasks; age sweeps them, then every task store id.
// Throughput: one request at a time, set by the chain sweep (one cell a cycle)
//   and the id sweep of the task store in age.
// Reset: synchronous; empties all queues, threshold back to 50, no clear pass.
module multilevel_feedback_queue_scheduler_top
   import mfq_pkg::*;
#(
   parameter int unsigned MAX_TASKS  = DEF_MAX_TASKS,
   parameter int unsigned NUM_LEVELS = DEF_NUM_LEVELS
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [TASK_W-1:0]   req_task_id,
   input  logic [LEVEL_W-1:0]  req_level,
   input  logic                req_slice_used_up,
   input  logic [TIME_W-1:0]   req_now,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [TASK_W-1:0]   rsp_task_out,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_rerun,
   output logic [PCOUNT_W-1:0] rsp_promoted_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [THR_W-1:0]    csr_wdata
);

   localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
   localparam int unsigned LVI_W = $clog2(NUM_LEVELS);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_PASS, S_AGE_APP, S_RESULT
   } state_type;

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [TASK_W-1:0]     id_ff, id_in;
   logic [LEVEL_W-1:0]    lvl_ff, lvl_in;
   logic                  used_ff, used_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [THR_W-1:0]      thr_ff, thr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      ac_ff, ac_in;
   logic [CNT_W-1:0]      pcount_ff, pcount_in;
   logic                  found_ff, found_in;
   logic [LEVEL_W-1:0]    minlev_ff, minlev_in;
   logic [MAX_TASKS-1:0]  queued_ff, queued_in;
   logic [MAX_TASKS-1:0]  promo_ff, promo_in;
   logic [CNT_W-1:0]      lvcnt_ff [NUM_LEVELS];
   logic [CNT_W-1:0]      lvcnt_in [NUM_LEVELS];
   logic [TASK_W-1:0]     res_task_ff, res_task_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  res_rerun_ff, res_rerun_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TASK_W-1:0]     rsp_task_ff, rsp_task_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_rerun_ff, rsp_rerun_in;
   logic [PCOUNT_W-1:0]   rsp_pcount_ff, rsp_pcount_in;

   entry_type             cell_q   [MAX_TASKS];
   entry_type             nbr_e    [MAX_TASKS];
   cell_ctl_type          cell_ctl [MAX_TASKS];
   logic                  shift_all;
   logic                  load_en;
   logic [CNT_W-1:0]      load_pos;
   entry_type             load_e;

   logic [IDX_W-1:0]      rd_addr;
   tinfo_type             rd_data;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   tinfo_type             wr_data;

   entry_type             head_e;
   logic                  id_ok;
   logic                  any_q;
   logic [LEVEL_W-1:0]    first_lev;
   logic [LEVEL_W-1:0]    new_lev;
   logic [TIME_W-1:0]     wait_t;
   logic [CNT_W-1:0]      prev_ac;

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      if (i == MAX_TASKS - 1) begin : g_top
         assign nbr_e[i] = '0;
      end else begin : g_mid
         assign nbr_e[i] = cell_q[i+1];
      end
      assign cell_ctl[i].shift = shift_all;
      assign cell_ctl[i].load  = load_en && (load_pos == CNT_W'(i));
      mfq_cell u_cell (
         .clock  (clock),
         .ctl    (cell_ctl[i]),
         .nbr_e  (nbr_e[i]),
         .load_e (load_e),
         .cell_e (cell_q[i])
      );
   end

   mfq_tinfo #(
      .DEPTH (MAX_TASKS),
      .IDX_W (IDX_W)
   ) u_tinfo (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign head_e  = cell_q[0];
   assign id_ok   = int'(id_ff) < int'(MAX_TASKS);
   assign wait_t  = now_ff - head_e.stamp;
   assign prev_ac = ac_ff - 1'b1;

   always_comb begin
      any_q     = 1'b0;
      first_lev = '0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (lvcnt_ff[l] != '0) begin
            any_q     = 1'b1;
            first_lev = LEVEL_W'(l);
         end
      end
   end

   always_comb begin
      if (int'(rd_data.level) + 1 < int'(NUM_LEVELS)) begin
         new_lev = rd_data.level + 1'b1;
      end else begin
         new_lev = rd_data.level;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      lvl_in        = lvl_ff;
      used_in       = used_ff;
      now_in        = now_ff;
      thr_in        = thr_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      ac_in         = ac_ff;
      pcount_in     = pcount_ff;
      found_in      = found_ff;
      minlev_in     = minlev_ff;
      queued_in     = queued_ff;
      promo_in      = promo_ff;
      lvcnt_in      = lvcnt_ff;
      res_task_in   = res_task_ff;
      res_status_in = res_status_ff;
      res_rerun_in  = res_rerun_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_task_in   = rsp_task_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rerun_in  = rsp_rerun_ff;
      rsp_pcount_in = rsp_pcount_ff;
      shift_all     = 1'b0;
      load_en       = 1'b0;
      load_pos      = cnt_ff;
      load_e        = head_e;
      rd_addr       = IDX_W'(id_ff);
      wr_en         = 1'b0;
      wr_addr       = IDX_W'(id_ff);
      wr_data       = rd_data;

      if (csr_valid) begin
         thr_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = IDX_W'(req_task_id);
            if (req_valid) begin
               op_in         = req_op;
               id_in         = req_task_id;
               lvl_in        = req_level;
               used_in       = req_slice_used_up;
               now_in        = req_now;
               res_task_in   = req_task_id;
               res_status_in = ST_OK;
               res_rerun_in  = 1'b0;
               pcount_in     = '0;
               found_in      = 1'b0;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESULT;
            rem_in   = cnt_ff;
            case (op_ff)
               OP_ENQUEUE: begin
                  if (!id_ok) begin
                     res_status_in = ST_NOT_FOUND;
                  end else if (!queued_ff[IDX_W'(id_ff)]) begin
                     load_en        = 1'b1;
                     load_e.id      = id_ff;
                     load_e.level   = (int'(lvl_ff) >= int'(NUM_LEVELS)) ?
                                      LEVEL_W'(NUM_LEVELS - 1) : lvl_ff;
                     load_e.stamp   = now_ff;
                     cnt_in         = cnt_ff + 1'b1;
                     wr_en          = 1'b1;
                     wr_data.level  = load_e.level;
                     wr_data.stamp  = now_ff;
                     queued_in[IDX_W'(id_ff)] = 1'b1;
                     lvcnt_in[LVI_W'(load_e.level)] =
                        lvcnt_ff[LVI_W'(load_e.level)] + 1'b1;
                  end
               end
               OP_DISPATCH: begin
                  if (!any_q) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     minlev_in = first_lev;
                     state_in  = S_PASS;
                  end
               end
               OP_RETURN: begin
                  if (!id_ok) begin
                     res_status_in = ST_NOT_FOUND;
                  end else if (!used_ff) begin
                     res_rerun_in = 1'b1;
                  end else if (!queued_ff[IDX_W'(id_ff)]) begin
                     load_en       = 1'b1;
                     load_e.id     = id_ff;
                     load_e.level  = new_lev;
                     load_e.stamp  = rd_data.stamp;
                     cnt_in        = cnt_ff + 1'b1;
                     wr_en         = 1'b1;
                     wr_data.level = new_lev;
                     queued_in[IDX_W'(id_ff)] = 1'b1;
                     lvcnt_in[LVI_W'(new_lev)] = lvcnt_ff[LVI_W'(new_lev)] + 1'b1;
                  end
               end
               OP_REMOVE: begin
                  if (!id_ok || !queued_ff[IDX_W'(id_ff)]) begin
                     res_status_in = ST_NOT_FOUND;
                  end else begin
                     queued_in[IDX_W'(id_ff)] = 1'b0;
                     state_in = S_PASS;
                  end
               end
               OP_AGE: begin
                  ac_in = '0;
                  if (cnt_ff == '0) begin
                     state_in = S_AGE_APP;
                  end else begin
                     state_in = S_PASS;
                  end
               end
               default: begin
                  res_status_in = ST_OK;
               end
            endcase
         end
         S_PASS: begin
            shift_all = 1'b1;
            load_pos  = cnt_ff - 1'b1;
            load_en   = 1'b1;
            rem_in    = rem_ff - 1'b1;
            case (op_ff)
               OP_DISPATCH: begin
                  if (!found_ff && head_e.level == minlev_ff) begin
                     load_en       = 1'b0;
                     found_in      = 1'b1;
                     res_task_in   = head_e.id;
                     queued_in[IDX_W'(head_e.id)] = 1'b0;
                     wr_en         = 1'b1;
                     wr_addr       = IDX_W'(head_e.id);
                     wr_data.level = head_e.level;
                     wr_data.stamp = now_ff;
                     lvcnt_in[LVI_W'(head_e.level)] =
                        lvcnt_ff[LVI_W'(head_e.level)] - 1'b1;
                  end
               end
               OP_REMOVE: begin
                  if (head_e.id == id_ff) begin
                     load_en = 1'b0;
                     lvcnt_in[LVI_W'(head_e.level)] =
                        lvcnt_ff[LVI_W'(head_e.level)] - 1'b1;
                  end
               end
               default: begin
                  if (head_e.level != '0 && wait_t > TIME_W'(thr_ff)) begin
                     load_en   = 1'b0;
                     pcount_in = pcount_ff + 1'b1;
                     promo_in[IDX_W'(head_e.id)] = 1'b1;
                     lvcnt_in[LVI_W'(head_e.level)] =
                        lvcnt_ff[LVI_W'(head_e.level)] - 1'b1;
                     lvcnt_in[LVI_W'(head_e.level - 1'b1)] =
                        lvcnt_ff[LVI_W'(head_e.level - 1'b1)] + 1'b1;
                  end
               end
            endcase
            if (!load_en) begin
               cnt_in = cnt_ff - 1'b1;
            end
            if (rem_ff == CNT_W'(1)) begin
               state_in = (op_ff == OP_AGE) ? S_AGE_APP : S_RESULT;
            end
         end
         S_AGE_APP: begin
            rd_addr = IDX_W'(ac_ff);
            ac_in   = ac_ff + 1'b1;
            if (ac_ff != '0 && promo_ff[IDX_W'(prev_ac)]) begin
               load_en       = 1'b1;
               load_e.id     = TASK_W'(prev_ac);
               load_e.level  = rd_data.level - 1'b1;
               load_e.stamp  = now_ff;
               cnt_in        = cnt_ff + 1'b1;
               wr_en         = 1'b1;
               wr_addr       = IDX_W'(prev_ac);
               wr_data.level = rd_data.level - 1'b1;
               wr_data.stamp = now_ff;
               promo_in[IDX_W'(prev_ac)] = 1'b0;
            end
            if (ac_ff == CNT_W'(MAX_TASKS)) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_task_in   = res_task_ff;
               rsp_status_in = res_status_ff;
               rsp_rerun_in  = res_rerun_ff;
               rsp_pcount_in = PCOUNT_W'(pcount_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THR_RESET;
         cnt_ff       <= '0;
         queued_ff    <= '0;
         promo_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            lvcnt_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         cnt_ff       <= cnt_in;
         queued_ff    <= queued_in;
         promo_ff     <= promo_in;
         rsp_valid_ff <= rsp_valid_in;
         lvcnt_ff     <= lvcnt_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      lvl_ff        <= lvl_in;
      used_ff       <= used_in;
      now_ff        <= now_in;
      rem_ff        <= rem_in;
      ac_ff         <= ac_in;
      pcount_ff     <= pcount_in;
      found_ff      <= found_in;
      minlev_ff     <= minlev_in;
      res_task_ff   <= res_task_in;
      res_status_ff <= res_status_in;
      res_rerun_ff  <= res_rerun_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rerun_ff  <= rsp_rerun_in;
      rsp_pcount_ff <= rsp_pcount_in;
   end

   assign req_stall          = state_ff != S_IDLE;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_task_out       = rsp_task_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_rerun          = rsp_rerun_ff;
   assign rsp_promoted_count = rsp_pcount_ff;

endmodule
